@@ hw/rtl/sfe_pkg.sv @@
// Shared types, character codes and the group encoder of the serial frame encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package sfe_pkg;

	localparam int MaxChars = 10;
	localparam int CntW     = $clog2(MaxChars + 1);

	localparam logic [7:0] CharStart = 8'h23;
	localparam logic [7:0] CharBase  = 8'h3D;
	localparam logic [7:0] CharCr    = 8'h0D;

	localparam logic [CntW-1:0] HdrLen  = CntW'(3);
	localparam logic [CntW-1:0] GrpLen  = CntW'(4);
	localparam logic [CntW-1:0] TailLen = CntW'(3);

	typedef logic [MaxChars-1:0][7:0] sfe_chars_t;
	typedef logic [3:0][7:0] sfe_group_t;

	// Frame state kept between beats.
	typedef struct packed {
		logic [15:0] held;
		logic [1:0]  fill;
		logic [11:0] sum;
		logic        in_frame;
	} sfe_state_t;

	// Characters caused by one input beat, first character in slot 0.
	typedef struct packed {
		sfe_chars_t      chars;
		logic [CntW-1:0] count;
		logic            closes;
	} sfe_batch_t;

	function automatic sfe_group_t sfe_enc_group(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		sfe_group_t g;
		g[0] = CharBase + {2'b00, a[7:2]};
		g[1] = CharBase + {2'b00, a[1:0], b[7:4]};
		g[2] = CharBase + {2'b00, b[3:0], c[7:6]};
		g[3] = CharBase + {2'b00, c[5:0]};
		return g;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sfe_frame_build.sv @@
// Combinational frame builder: turns one input beat plus frame state into its
// characters and the next frame state. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfe_frame_build (
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_data,
	input  wire logic        is_first,
	input  wire logic        is_last,
	input  wire logic [7:0]  command,
	input  wire logic [7:0]  address,
	input  wire sfe_pkg::sfe_state_t state,
	output sfe_pkg::sfe_batch_t      batch,
	output sfe_pkg::sfe_state_t      state_next
);
	import sfe_pkg::*;

	sfe_state_t  st_e;
	logic        active;
	logic        grp_data, grp_flush, grp_any;
	logic [15:0] held_d;
	logic [1:0]  fill_d;
	logic [7:0]  ga, gb, gc;
	sfe_group_t  grp;
	logic [2:0][7:0] hdr, tail;
	logic [11:0] sum_hdr, sum_grp, sum_pre;

	always_comb begin
		// A first beat restarts the frame from a clean state.
		st_e = state;
		if (is_first) begin
			st_e = '0;
		end
		active = is_first | state.in_frame;

		held_d   = st_e.held;
		fill_d   = st_e.fill;
		grp_data = 1'b0;
		if (has_data) begin
			unique case (st_e.fill)
				2'd0: begin
					held_d = {data_byte, 8'h00};
					fill_d = 2'd1;
				end
				2'd1: begin
					held_d = {st_e.held[15:8], data_byte};
					fill_d = 2'd2;
				end
				default: begin
					grp_data = 1'b1;
					held_d   = '0;
					fill_d   = 2'd0;
				end
			endcase
		end
		grp_flush = is_last & (fill_d != 2'd0);
		grp_any   = grp_data | grp_flush;

		ga = grp_data ? st_e.held[15:8] : held_d[15:8];
		gb = grp_data ? st_e.held[7:0] : ((fill_d == 2'd1) ? 8'h00 : held_d[7:0]);
		gc = grp_data ? data_byte : 8'h00;
		grp = sfe_enc_group(ga, gb, gc);

		hdr[0] = CharStart;
		hdr[1] = address;
		hdr[2] = command;

		sum_hdr = is_first ? (12'(CharStart) + 12'(address) + 12'(command)) : 12'h000;
		sum_grp = grp_any ? (12'(grp[0]) + 12'(grp[1]) + 12'(grp[2]) + 12'(grp[3])) : 12'h000;
		sum_pre = st_e.sum + sum_hdr + sum_grp;

		tail[0] = CharBase + {2'b00, sum_pre[11:6]};
		tail[1] = CharBase + {2'b00, sum_pre[5:0]};
		tail[2] = CharCr;

		batch.chars = '0;
		unique case ({is_first, grp_any})
			2'b00: begin
				for (int i = 0; i < 3; i++) batch.chars[i] = tail[i];
			end
			2'b10: begin
				for (int i = 0; i < 3; i++) batch.chars[i] = hdr[i];
				for (int i = 0; i < 3; i++) batch.chars[i + 3] = tail[i];
			end
			2'b01: begin
				for (int i = 0; i < 4; i++) batch.chars[i] = grp[i];
				for (int i = 0; i < 3; i++) batch.chars[i + 4] = tail[i];
			end
			default: begin
				for (int i = 0; i < 3; i++) batch.chars[i] = hdr[i];
				for (int i = 0; i < 4; i++) batch.chars[i + 3] = grp[i];
				for (int i = 0; i < 3; i++) batch.chars[i + 7] = tail[i];
			end
		endcase

		batch.count = '0;
		if (active) begin
			batch.count = (is_first ? HdrLen : '0) + (grp_any ? GrpLen : '0)
				+ (is_last ? TailLen : '0);
		end
		batch.closes = is_last;

		// Closing a frame returns everything to reset; ignored beats leave state alone.
		state_next = state;
		if (active) begin
			if (is_last) begin
				state_next = '0;
			end else begin
				state_next.held     = held_d;
				state_next.fill     = fill_d;
				state_next.sum      = sum_pre;
				state_next.in_frame = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sfe_char_queue.sv @@
// Character queue: holds the characters of one beat in a shift line and feeds
// them one per cycle into the output register while the output is not stalled. Depends on sfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfe_char_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire sfe_pkg::sfe_batch_t batch,
	output logic       can_load,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] out_char,
	output logic       frame_end,
	output logic       run_last
);
	import sfe_pkg::*;

	sfe_chars_t      chars_q;
	logic [CntW-1:0] cnt_q;
	logic            end_q;
	logic            out_valid_q, frame_end_q, run_last_q;
	logic [7:0]      out_char_q;
	logic            out_free, pop, last_one;

	assign out_free = !out_valid_q || out_ready;
	assign pop      = out_free && (cnt_q != '0);
	assign last_one = (cnt_q == CntW'(1));
	assign can_load = (cnt_q == '0) || (last_one && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			end_q <= 1'b0;
		end else if (load && (batch.count != '0)) begin
			cnt_q <= batch.count;
			end_q <= batch.closes;
		end else if (pop) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && (batch.count != '0)) begin
			chars_q <= batch.chars;
		end else if (pop) begin
			chars_q <= {8'h00, chars_q[MaxChars-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char_q  <= chars_q[0];
			run_last_q  <= last_one;
			frame_end_q <= last_one && end_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/serial_frame_encoder_checksum.sv @@
// Serial frame encoder with 12-bit character checksum (top level).
// Depends on sfe_pkg, sfe_frame_build and sfe_char_queue.
//
// Turns input beats into the characters of an ASCII frame, one output beat
// per character. A first beat emits '#', the address byte and the command
// byte; payload bytes are packed three to a group and each group leaves as
// four characters '='+6-bit value. A last beat flushes a partial group
// (zero padded), then sends '='+sum[11:6], '='+sum[5:0] and a carriage
// return, where sum is the 12-bit total of all frame characters before it.
// Beats outside a frame (no first beat seen) are swallowed silently.
// Timing: a beat is decoded in the cycle it is accepted and its characters
// (0 to 10) are loaded into a shift line; the output port then moves one
// character per cycle while out_ready is high. The input side takes the next
// beat in the cycle the last queued character goes to the output register,
// so a new beat is not loaded before the shift line of the last one has
// emptied. The first character of a beat goes through the shift line and
// then the output register; output stalls hold off the input the same way.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_encoder_checksum (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_data,
	input  wire logic       is_first,
	input  wire logic       is_last,
	input  wire logic [7:0] command,
	input  wire logic [7:0] address,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            frame_end,
	output logic            run_last
);
	import sfe_pkg::*;

	sfe_state_t state_q, state_next;
	sfe_batch_t batch;
	logic       can_load, accept;

	assign in_ready = can_load;
	assign accept   = in_valid && can_load;

	// Beat decode: header, group packing, checksum and next frame state.
	sfe_frame_build u_build (
		.data_byte  (data_byte),
		.has_data   (has_data),
		.is_first   (is_first),
		.is_last    (is_last),
		.command    (command),
		.address    (address),
		.state      (state_q),
		.batch      (batch),
		.state_next (state_next)
	);

	// Frame state advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	// Character queue and output register.
	sfe_char_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.batch     (batch),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule
`default_nettype wire

@@ hw/rtl/sfe_checker.sv @@
// Port-level checks for the serial frame encoder, bound to the top level.
// Depends on sfe_pkg and serial_frame_encoder_checksum.
`timescale 1ns / 1ps
`default_nettype none
module sfe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_char,
	input wire logic       frame_end,
	input wire logic       run_last
);
	import sfe_pkg::*;

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(frame_end) && $stable(run_last))
		else $error("output beat changed while stalled");

	// The frame terminator is always the last character of its beat.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame end without run last");

	// The frame terminator is a carriage return.
	a_end_cr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> out_char == CharCr)
		else $error("frame end on a character other than CR");

endmodule

bind serial_frame_encoder_checksum sfe_checker u_sfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_char  (out_char),
	.frame_end (frame_end),
	.run_last  (run_last)
);
`default_nettype wire
